>>> src/rrrt_pkg.sv
// ----------------------------------------------------------------------------
// rrrt_pkg
// Shared types, sizes and codes for the read reply reassembly tracker.
// ----------------------------------------------------------------------------
package rrrt_pkg;

   // Table geometry
   localparam int SLOTS    = 16;
   localparam int MAP_BITS = 32;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(MAP_BITS + 1);

   // Item kinds
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_REPLY   = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_MATCHED  = 2'd2;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [31:0] file_id;
      logic [31:0] reply_id;
      logic [31:0] start_sector;
      logic [7:0]  sector_count;
      logic        is_write;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot;
      logic [31:0] assigned_id;
      logic [4:0]  copy_offset;
      logic [5:0]  copy_length;
      logic        overrun;
      logic        complete;
   } rsp_payload_type;

   // One table entry as held in the slot memory
   typedef struct packed {
      logic                is_write;
      logic [31:0]         file_id;
      logic [31:0]         req_id;
      logic [31:0]         start;
      logic [CNT_W-1:0]    count;
      logic [MAP_BITS-1:0] map;
   } slot_entry_type;

   // Outcome of checking one entry against a reply
   typedef struct packed {
      logic             hit;
      logic             done;
      logic             over;
      logic [CNT_W-1:0] off;
      logic [CNT_W-1:0] len;
   } match_type;

   // Mask with the lowest n bits set
   function automatic logic [MAP_BITS-1:0] low_ones(input logic [CNT_W-1:0] n);
      logic [MAP_BITS-1:0] m;
      for (int b = 0; b < MAP_BITS; b++) begin
         m[b] = (int'(n) > b);
      end
      return m;
   endfunction

endpackage

>>> src/rrrt_if.sv
// ----------------------------------------------------------------------------
// rrrt_if
// Valid/ready channels for requests in and results out.
// ----------------------------------------------------------------------------
interface rrrt_req_if;
   import rrrt_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rrrt_rsp_if;
   import rrrt_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/rrrt_ram.sv
// ----------------------------------------------------------------------------
// rrrt_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rrrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> src/rrrt_match.sv
// ----------------------------------------------------------------------------
// rrrt_match
// Checks one slot entry against a read reply, clamps the reply to the request
// and builds the updated sector map.
// ----------------------------------------------------------------------------
module rrrt_match (
   input  rrrt_pkg::slot_entry_type       entry,
   input  logic                           entry_valid,
   input  rrrt_pkg::req_payload_type      reply,
   output rrrt_pkg::match_type            result,
   output logic [rrrt_pkg::MAP_BITS-1:0]  new_map
);
   import rrrt_pkg::*;

   logic [32:0]         diff;
   logic                in_range;
   logic [CNT_W-1:0]    off;
   logic [CNT_W-1:0]    remain;
   logic                over;
   logic [CNT_W-1:0]    len;
   logic [MAP_BITS-1:0] need;

   // Position of the reply start inside the request
   assign diff     = {1'b0, reply.start_sector} - {1'b0, entry.start};
   assign in_range = !diff[32] && (diff[31:0] < 32'(entry.count));
   assign off      = diff[CNT_W-1:0];

   // Clamp the reply to the request end
   assign remain = entry.count - off;
   assign over   = reply.sector_count > 8'(remain);
   assign len    = over ? remain : reply.sector_count[CNT_W-1:0];

   // Mark covered sectors and check for a full map
   assign new_map = entry.map | (low_ones(len) << off);
   assign need    = low_ones(entry.count);

   always_comb begin
      result.hit  = entry_valid && !entry.is_write
                    && (entry.file_id == reply.file_id)
                    && (entry.req_id == reply.reply_id)
                    && in_range;
      result.done = ((new_map & need) == need);
      result.over = over;
      result.off  = off;
      result.len  = len;
   end

endmodule

>>> src/read_reply_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// read_reply_reassembly_tracker
// Slot table of outstanding sector requests; read replies are matched,
// clamped and marked in a per-slot sector map until the request completes.
// ----------------------------------------------------------------------------
// Order: a request passes from the idle step through the finish step to the result
//    register; a reply is held, slots are read and checked from slot zero until one
//    matches or all are checked, then it too passes through the finish step.
// Throughput: one item at a time; the next request is taken once the result
//    register has it. The reply search reads one slot entry per cycle from
//    the single read port of the slot memory, lowest slot first.
// Reset: all slots free, id counter at one; memory contents are not cleared.
// ----------------------------------------------------------------------------
module read_reply_reassembly_tracker (
   input  logic       clock,
   input  logic       reset,
   rrrt_req_if.sink   req_chan,
   rrrt_rsp_if.source rsp_chan
);
   import rrrt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_type;

   state_type           state_ff, state_in;
   logic [SLOTS-1:0]    slot_valid_ff, slot_valid_in;
   logic [31:0]         next_id_ff, next_id_in;
   logic [SLOT_W:0]     iss_ff, iss_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0]   chk_idx_ff, chk_idx_in;
   req_payload_type     reply_ff, reply_in;
   rsp_payload_type     pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                free_found;
   logic [SLOT_W-1:0]   free_idx;
   logic [CNT_W-1:0]    req_count;
   logic                ram_wr_en;
   logic [SLOT_W-1:0]   ram_wr_addr;
   slot_entry_type      ram_wr_data;
   logic                ram_rd_en;
   logic [SLOT_W-1:0]   ram_rd_addr;
   slot_entry_type      rd_entry;
   match_type           mres;
   logic [MAP_BITS-1:0] new_map;
   logic                out_free;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Find the lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // Clamp the request count into 1..MAP_BITS
   always_comb begin
      if (req_chan.data.sector_count == 8'd0) begin
         req_count = CNT_W'(1);
      end else if (req_chan.data.sector_count > 8'(MAP_BITS)) begin
         req_count = CNT_W'(MAP_BITS);
      end else begin
         req_count = req_chan.data.sector_count[CNT_W-1:0];
      end
   end

   rrrt_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_entry)
   );

   rrrt_match u_match (
      .entry       (rd_entry),
      .entry_valid (slot_valid_ff[chk_idx_ff]),
      .reply       (reply_ff),
      .result      (mres),
      .new_map     (new_map)
   );

   // Sequence requests, reply search and result hand-off
   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      next_id_in    = next_id_ff;
      iss_in        = iss_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      reply_in      = reply_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = free_idx;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = iss_ff[SLOT_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_chan.data.kind == KIND_REQUEST) begin
               pend_in = '0;
               if (free_found) begin
                  // Take the slot and hand out the next id
                  ram_wr_en                = 1'b1;
                  ram_wr_data.is_write     = req_chan.data.is_write;
                  ram_wr_data.file_id      = req_chan.data.file_id;
                  ram_wr_data.req_id       = next_id_ff;
                  ram_wr_data.start        = req_chan.data.start_sector;
                  ram_wr_data.count        = req_count;
                  ram_wr_data.map          = '0;
                  slot_valid_in[free_idx]  = 1'b1;
                  next_id_in               = next_id_ff + 32'd1;
                  pend_in.status           = STATUS_ACCEPTED;
                  pend_in.slot             = 4'(free_idx);
                  pend_in.assigned_id      = next_id_ff;
               end else begin
                  pend_in.status = STATUS_FULL;
               end
               state_in = S_FINISH;
            end else if (req_fire) begin
               // Hold the reply and start the search at slot zero
               reply_in = req_chan.data;
               iss_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Issue the next read while checking the previous one
            if (iss_ff < (SLOT_W + 1)'(SLOTS)) begin
               ram_rd_en  = 1'b1;
               iss_in     = iss_ff + (SLOT_W + 1)'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[SLOT_W-1:0];
            end
            pend_in = '0;
            if (chk_vld_ff && mres.hit) begin
               // Write back the marked map, free the slot when complete
               ram_wr_en       = 1'b1;
               ram_wr_addr     = chk_idx_ff;
               ram_wr_data     = rd_entry;
               ram_wr_data.map = new_map;
               if (mres.done) begin
                  slot_valid_in[chk_idx_ff] = 1'b0;
               end
               pend_in.status      = STATUS_MATCHED;
               pend_in.slot        = 4'(chk_idx_ff);
               pend_in.copy_offset = 5'(mres.off);
               pend_in.copy_length = 6'(mres.len);
               pend_in.overrun     = mres.over;
               pend_in.complete    = mres.done;
               chk_vld_in          = 1'b0;
               state_in            = S_FINISH;
            end else if (!chk_vld_ff && iss_ff == (SLOT_W + 1)'(SLOTS)) begin
               pend_in.status = STATUS_NO_MATCH;
               state_in       = S_FINISH;
            end
         end
         S_FINISH: begin
            // Hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, slot valid bits and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_valid_ff <= '0;
         next_id_ff    <= 32'd1;
         iss_ff        <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         next_id_ff    <= next_id_in;
         iss_ff        <= iss_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      chk_idx_ff  <= chk_idx_in;
      reply_ff    <= reply_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The id counter moves only for a request that took a slot
   assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && next_id_ff != $past(next_id_ff))
      |-> $past(req_fire && req_chan.data.kind == KIND_REQUEST && free_found))
      else $error("id counter moved without an accepted request");

   // A completed reply frees its slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && chk_vld_ff && mres.hit && mres.done)
      |=> !slot_valid_ff[$past(chk_idx_ff)])
      else $error("completed slot still valid");

   // An accepted request occupies the slot it was given
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.data.kind == KIND_REQUEST && free_found)
      |=> slot_valid_ff[$past(free_idx)])
      else $error("taken slot not marked valid");

   // A new result appears only after the finish step
   assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside the finish step");

endmodule
